### design/cps_pkg.sv
// cps_pkg: shared constants and types for the change priority send scheduler
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package cps_pkg;

	// default sizing of the block
	localparam int MAX_SIGNALS_DEF = 32;
	localparam int MAX_SEND_DEF    = 16;
	localparam int WORD_WIDTH_DEF  = 32;

	// fixed field widths on the ports
	localparam int VALUE_W     = 32;
	localparam int INDEX_W     = 5;
	localparam int SIGCNT_W    = 6;
	localparam int SENDCNT_W   = 5;
	localparam int CFG_DATA_W  = 6;
	localparam int CFG_INDEX_W = 1;

	// register map
	localparam logic [CFG_INDEX_W-1:0] REG_SIGNAL_COUNT = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_SEND_COUNT   = 1'b1;

	localparam logic [SIGCNT_W-1:0]  SIGNAL_COUNT_RST = 6'd32;
	localparam logic [SENDCNT_W-1:0] SEND_COUNT_RST   = 5'd4;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CMP  = 4'b0010,
		ST_WALK = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

endpackage

### design/cps_value_if.sv
// cps_value_if: valid/ready channel carrying one monitored signal word
// depends on cps_pkg for the word width
`timescale 1ns / 1ps

interface cps_value_if;
	logic                           valid;
	logic                           ready;
	logic [cps_pkg::VALUE_W-1:0]    signal_value;

	modport source (output valid, output signal_value, input ready);
	modport sink   (input valid, input signal_value, output ready);
endinterface

### design/cps_index_if.sv
// cps_index_if: valid/ready channel carrying one scheduled signal index
// depends on cps_pkg for the index width
`timescale 1ns / 1ps

interface cps_index_if;
	logic                           valid;
	logic                           ready;
	logic [cps_pkg::INDEX_W-1:0]    signal_index;
	logic                           last_index;

	modport source (output valid, output signal_index, output last_index, input ready);
	modport sink   (input valid, input signal_index, input last_index, output ready);
endinterface

### design/change_priority_send_scheduler_top.sv
// change_priority_send_scheduler_top: frame loader, reorder walk and index emitter
// depends on cps_pkg, cps_value_if and cps_index_if
`timescale 1ns / 1ps

// Takes one signal word per request, in signal order, and flags the signals whose
// word differs from the one stored in the previous frame. For each word the
// previous value is read from the value memory, then compared and written
// back. After the last word of a frame (once the round-robin warm-up is over) a
// walk over the order list moves changed signals forward, one list position per
// cycle; then send_count indices leave, one per cycle while the sink is ready,
// the last one marked with last_index. The order list is kept rotated so that
// the send window always starts at entry zero: each emitted index rotates the
// list by one. No request is taken during the compare, walk or emit phases. A
// write to either register restarts scheduling.
module change_priority_send_scheduler_top #(
	parameter int MAX_SIGNALS = cps_pkg::MAX_SIGNALS_DEF,
	parameter int MAX_SEND    = cps_pkg::MAX_SEND_DEF,
	parameter int WORD_WIDTH  = cps_pkg::WORD_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	cps_value_if.sink                          values,
	cps_index_if.source                        indices,
	input  logic                               write_enable,
	input  logic [cps_pkg::CFG_INDEX_W-1:0]    write_index,
	input  logic [cps_pkg::CFG_DATA_W-1:0]     write_data
);

	localparam int IDX_W  = $clog2(MAX_SIGNALS);
	localparam int CNT_W  = $clog2(MAX_SIGNALS + 1);
	localparam int POS_W  = CNT_W + 1;
	localparam int ACC_W  = CNT_W + 1;
	localparam int SRAW_W = $clog2(MAX_SEND + 1) < 1 ? 1 : $clog2(MAX_SEND + 1);

	logic [cps_pkg::SIGCNT_W-1:0]  signal_count_q;
	logic [cps_pkg::SENDCNT_W-1:0] send_count_q;
	logic [CNT_W-1:0]              n_eff;
	logic [CNT_W-1:0]              s_eff;
	logic [SRAW_W-1:0]             s_raw;

	cps_pkg::state_t               state_q;

	logic [WORD_WIDTH-1:0]         prev_mem [MAX_SIGNALS];
	logic [WORD_WIDTH-1:0]         rd_q;
	logic [WORD_WIDTH-1:0]         word_q;
	logic [cps_pkg::VALUE_W+WORD_WIDTH-1:0] word_ext;
	logic [WORD_WIDTH-1:0]         word_in;

	logic [IDX_W-1:0]              load_q;
	logic [MAX_SIGNALS-1:0]        flag_q;
	logic [IDX_W-1:0]              rel_q [MAX_SIGNALS];
	logic [IDX_W-1:0]              walk_q;
	logic [POS_W-1:0]              cp_q;
	logic [ACC_W-1:0]              acc_q;
	logic [CNT_W-1:0]              emit_q;

	logic                          in_fire;
	logic                          out_fire;
	logic                          cfg_restart;
	logic                          load_last;
	logic                          walk_last;
	logic                          emit_last;
	logic                          warm_done;
	logic [IDX_W-1:0]              walk_sig;
	logic                          walk_hit;
	logic                          walk_move;
	logic [POS_W-1:0]              cp_sub;
	logic                          cp_wrap;
	logic [IDX_W+cps_pkg::INDEX_W-1:0] idx_ext;

	// effective counts after clamping
	always_comb begin
		if (signal_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (32'(signal_count_q) > 32'(MAX_SIGNALS)) begin
			n_eff = CNT_W'(MAX_SIGNALS);
		end else begin
			n_eff = CNT_W'(signal_count_q);
		end
		if (send_count_q == '0) begin
			s_raw = SRAW_W'(1);
		end else if (32'(send_count_q) > 32'(MAX_SEND)) begin
			s_raw = SRAW_W'(MAX_SEND);
		end else begin
			s_raw = SRAW_W'(send_count_q);
		end
		if (32'(s_raw) > 32'(n_eff)) begin
			s_eff = n_eff;
		end else begin
			s_eff = CNT_W'(s_raw);
		end
	end

	assign in_fire     = values.valid && values.ready;
	assign out_fire    = indices.valid && indices.ready;
	assign cfg_restart = write_enable &&
		(write_index == cps_pkg::REG_SIGNAL_COUNT || write_index == cps_pkg::REG_SEND_COUNT);

	assign word_ext = {{WORD_WIDTH{1'b0}}, values.signal_value};
	assign word_in  = word_ext[WORD_WIDTH-1:0];

	assign load_last = (CNT_W'(load_q) + CNT_W'(1)) == n_eff;
	assign walk_last = (CNT_W'(walk_q) + CNT_W'(1)) == n_eff;
	assign emit_last = (emit_q + CNT_W'(1)) == s_eff;
	// warm-up is over once the frames so far cover the whole signal list
	assign warm_done = acc_q >= ACC_W'(n_eff);

	assign walk_sig  = rel_q[walk_q];
	assign walk_hit  = flag_q[walk_sig];
	assign walk_move = walk_hit && (POS_W'(walk_q) > cp_q);

	assign cp_sub  = (cp_q > POS_W'(s_eff)) ? cp_q - POS_W'(s_eff) : '0;
	assign cp_wrap = cp_sub > POS_W'(n_eff - s_eff);

	assign values.ready = (state_q == cps_pkg::ST_IDLE);
	assign indices.valid = (state_q == cps_pkg::ST_EMIT);
	assign idx_ext = {{cps_pkg::INDEX_W{1'b0}}, rel_q[0]};
	assign indices.signal_index = idx_ext[cps_pkg::INDEX_W-1:0];
	assign indices.last_index = emit_last;

	// previous value memory, read on request, written back in the compare state
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_q   <= prev_mem[load_q];
			word_q <= word_in;
		end
		if (state_q == cps_pkg::ST_CMP) begin
			prev_mem[load_q] <= word_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signal_count_q <= cps_pkg::SIGNAL_COUNT_RST;
			send_count_q   <= cps_pkg::SEND_COUNT_RST;
			state_q        <= cps_pkg::ST_IDLE;
			load_q         <= '0;
			flag_q         <= '0;
			walk_q         <= '0;
			cp_q           <= '0;
			acc_q          <= '0;
			emit_q         <= '0;
			for (int p = 0; p < MAX_SIGNALS; p++) begin
				rel_q[p] <= IDX_W'(p);
			end
		end else begin
			case (state_q)
				cps_pkg::ST_IDLE: begin
					if (in_fire) begin
						state_q <= cps_pkg::ST_CMP;
					end
				end
				cps_pkg::ST_CMP: begin
					flag_q[load_q] <= (word_q != rd_q);
					if (load_last) begin
						load_q <= '0;
						walk_q <= '0;
						emit_q <= '0;
						if (warm_done) begin
							state_q <= cps_pkg::ST_WALK;
						end else begin
							acc_q   <= acc_q + ACC_W'(s_eff);
							state_q <= cps_pkg::ST_EMIT;
						end
					end else begin
						load_q  <= load_q + IDX_W'(1);
						state_q <= cps_pkg::ST_IDLE;
					end
				end
				cps_pkg::ST_WALK: begin
					// changed entry behind the change position: rotate it down to there
					if (walk_move) begin
						for (int p = 0; p < MAX_SIGNALS; p++) begin
							if (POS_W'(p) == cp_q) begin
								rel_q[p] <= walk_sig;
							end else if (POS_W'(p) > cp_q && IDX_W'(p) <= walk_q) begin
								rel_q[p] <= rel_q[(p + MAX_SIGNALS - 1) % MAX_SIGNALS];
							end
						end
					end
					if (walk_hit) begin
						cp_q <= cp_q + POS_W'(1);
					end
					if (walk_last) begin
						state_q <= cps_pkg::ST_EMIT;
					end else begin
						walk_q <= walk_q + IDX_W'(1);
					end
				end
				cps_pkg::ST_EMIT: begin
					if (out_fire) begin
						// rotate the active part of the list so the window stays at entry zero
						for (int p = 0; p < MAX_SIGNALS; p++) begin
							if (CNT_W'(p) + CNT_W'(1) == n_eff) begin
								rel_q[p] <= rel_q[0];
							end else if (CNT_W'(p) + CNT_W'(1) < n_eff) begin
								rel_q[p] <= rel_q[(p + 1) % MAX_SIGNALS];
							end
						end
						if (emit_last) begin
							emit_q  <= '0;
							state_q <= cps_pkg::ST_IDLE;
							if (cp_wrap) begin
								cp_q  <= '0;
								acc_q <= '0;
							end else begin
								cp_q <= cp_sub;
							end
						end else begin
							emit_q <= emit_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= cps_pkg::ST_IDLE;
				end
			endcase

			if (write_enable) begin
				case (write_index)
					cps_pkg::REG_SIGNAL_COUNT: signal_count_q <= write_data;
					cps_pkg::REG_SEND_COUNT:   send_count_q   <= write_data[cps_pkg::SENDCNT_W-1:0];
					default: ;
				endcase
			end
			// register write restarts scheduling, previous values are kept
			if (cfg_restart) begin
				load_q <= '0;
				flag_q <= '0;
				cp_q   <= '0;
				acc_q  <= '0;
				emit_q <= '0;
				for (int p = 0; p < MAX_SIGNALS; p++) begin
					rel_q[p] <= IDX_W'(p);
				end
			end
		end
	end

	a_ready_only_when_not_sending: assert property (@(posedge clk) disable iff (!arst_n)
		values.ready |-> !indices.valid)
		else $error("request taken while indices are pending");

	a_last_returns_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && indices.last_index |=> values.ready)
		else $error("block did not return to loading after the last index");

	a_emit_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		indices.valid |-> emit_q < s_eff)
		else $error("emit counter beyond send count");

	a_change_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		values.ready |-> cp_q <= POS_W'(n_eff - s_eff))
		else $error("change position outside the window range between frames");

	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(load_q) < n_eff)
		else $error("load counter beyond signal count");

endmodule
